### rtl/hashed_set_with_random_pick_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the hashed set checker
// Each macro expects clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef HASHED_SET_WITH_RANDOM_PICK_MACROS_SVH
`define HASHED_SET_WITH_RANDOM_PICK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSWRP_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HSWRP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hswrp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hswrp_pkg
// Types, codes and constants shared by the hashed set modules.
// ---------------------------------------------------------------------------
package hswrp_pkg;

  localparam int SLOTS_DEF = 1024;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int DRAW_W   = 31;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int DIV_CNT_W = $clog2(DRAW_W);

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_COLLIDE = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [DRAW_W-1:0]         random_draw;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] picked_value;
    logic [COUNT_W-1:0]        count_after;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    idle;
    logic    load;
    logic    hash_init;
    logic    hash_src_last;
    logic    hash_step;
    logic    slot_rd;
    logic    slot_keep;
    logic    ins_wr;
    logic    pos_keep;
    logic    last_rd;
    logic    move_wr;
    logic    repoint_wr;
    logic    clear_wr;
    logic    div_init;
    logic    div_step;
    logic    pick_rd;
    logic    clr_wr;
    logic    finish;
    status_t status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            hash_last;
    logic            slot_used;
    logic            key_match;
    logic            count_zero;
    logic            count_full;
    logic            div_last;
    logic            clr_last;
    logic            out_free;
  } sts_t;

endpackage

### rtl/hswrp_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hswrp_ctrl
// Sequencer for insert, remove and random pick, plus the slot clearing pass.
// ---------------------------------------------------------------------------
module hswrp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  hswrp_pkg::sts_t  sts,
  output hswrp_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_HASH_V, S_SLOT_RD, S_SLOT_CHK, S_RM_LAST,
    S_HASH_L, S_REPOINT, S_RM_CLEAR, S_DIV, S_PICK_RD, S_DONE
  } state_t;

  state_t              state;
  hswrp_pkg::status_t  st;
  logic                rm_hit;

  assign rm_hit = sts.slot_used && sts.key_match && !sts.count_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      st    <= hswrp_pkg::ST_OK;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) state <= S_DECODE;
        end
        S_DECODE: begin
          st <= hswrp_pkg::ST_OK;
          unique case (sts.op)
            hswrp_pkg::OP_INSERT, hswrp_pkg::OP_REMOVE: state <= S_HASH_V;
            hswrp_pkg::OP_PICK: begin
              if (sts.count_zero) begin
                st    <= hswrp_pkg::ST_EMPTY;
                state <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_HASH_V: begin
          if (sts.hash_last) state <= S_SLOT_RD;
        end
        S_SLOT_RD: state <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          if (sts.op == hswrp_pkg::OP_INSERT) begin
            if (sts.slot_used) begin
              st <= sts.key_match ? hswrp_pkg::ST_PRESENT : hswrp_pkg::ST_COLLIDE;
            end
            state <= S_DONE;
          end else if (rm_hit) begin
            state <= S_RM_LAST;
          end else begin
            st    <= hswrp_pkg::ST_ABSENT;
            state <= S_DONE;
          end
        end
        S_RM_LAST: state <= S_HASH_L;
        S_HASH_L: begin
          if (sts.hash_last) state <= S_REPOINT;
        end
        S_REPOINT:  state <= S_RM_CLEAR;
        S_RM_CLEAR: state <= S_DONE;
        S_DIV: begin
          if (sts.div_last) state <= S_PICK_RD;
        end
        S_PICK_RD: state <= S_DONE;
        S_DONE: begin
          if (sts.out_free) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.status = st;
    unique case (state)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE: begin
        cmd.idle = 1'b1;
        cmd.load = req_valid;
      end
      S_DECODE: begin
        cmd.hash_init = (sts.op == hswrp_pkg::OP_INSERT) ||
                        (sts.op == hswrp_pkg::OP_REMOVE);
        cmd.div_init  = (sts.op == hswrp_pkg::OP_PICK) && !sts.count_zero;
      end
      S_HASH_V, S_HASH_L: cmd.hash_step = 1'b1;
      S_SLOT_RD: begin
        cmd.slot_rd   = 1'b1;
        cmd.slot_keep = 1'b1;
      end
      S_SLOT_CHK: begin
        if (sts.op == hswrp_pkg::OP_INSERT) begin
          cmd.ins_wr = !sts.slot_used && !sts.count_full;
        end else begin
          cmd.pos_keep = rm_hit;
          cmd.last_rd  = rm_hit;
        end
      end
      S_RM_LAST: begin
        cmd.move_wr       = 1'b1;
        cmd.hash_init     = 1'b1;
        cmd.hash_src_last = 1'b1;
      end
      S_REPOINT:  cmd.repoint_wr = 1'b1;
      S_RM_CLEAR: cmd.clear_wr   = 1'b1;
      S_DIV:      cmd.div_step   = 1'b1;
      S_PICK_RD:  cmd.pick_rd    = 1'b1;
      S_DONE:     cmd.finish     = sts.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/hswrp_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hswrp_dp
// Slot table, dense list, hash unit, remainder unit and result register.
// ---------------------------------------------------------------------------
module hswrp_dp #(
  parameter int SLOTS = hswrp_pkg::SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  hswrp_pkg::cmd_t  cmd,
  input  hswrp_pkg::req_t  req,
  output hswrp_pkg::sts_t  sts,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output hswrp_pkg::rsp_t  rsp
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int VW     = hswrp_pkg::VALUE_W;
  localparam int SW     = 1 + VW + SLOT_W;
  localparam int DW     = hswrp_pkg::DRAW_W;
  localparam int DCW    = hswrp_pkg::DIV_CNT_W;
  localparam logic [SLOT_W-1:0] BASIS_LO = hswrp_pkg::FNV_BASIS[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] PRIME_LO = hswrp_pkg::FNV_PRIME[SLOT_W-1:0];

  // captured item
  logic [hswrp_pkg::OP_W-1:0] op;
  logic [VW-1:0]              val;

  // hash unit: only the low index bits are kept, they never depend on higher ones
  logic [SLOT_W-1:0] h;
  logic [SLOT_W-1:0] hx;
  logic [SLOT_W-1:0] hm;
  logic [VW-1:0]     hsrc;
  logic [1:0]        hcnt;

  // table state
  logic [SW-1:0]     slot_mem [SLOTS];
  logic [VW-1:0]     dense_mem [SLOTS];
  logic [SW-1:0]     slot_q;
  logic [VW-1:0]     dense_q;
  logic [SLOT_W-1:0] s;
  logic [SLOT_W-1:0] pos;
  logic [VW-1:0]     last_val;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] clr_idx;

  // remainder unit
  logic [DW-1:0]     dsh;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rs;
  logic [DCW-1:0]    dcnt;

  // slot and dense port selection
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wa;
  logic [SW-1:0]     slot_wd;
  logic              dense_we;
  logic [SLOT_W-1:0] dense_wa;
  logic [VW-1:0]     dense_wd;
  logic              dense_re;
  logic [SLOT_W-1:0] dense_ra;

  assign hx = h ^ SLOT_W'(hsrc[7:0]);
  // slot index is the hash masked by SLOTS-1
  assign hm = h & SLOT_W'(SLOTS - 1);
  assign rs = {rem, dsh[DW-1]};

  always_comb begin
    slot_we = cmd.clr_wr || cmd.ins_wr || cmd.repoint_wr || cmd.clear_wr;
    slot_wa = clr_idx;
    slot_wd = '0;
    if (cmd.ins_wr) begin
      slot_wa = s;
      slot_wd = {1'b1, val, SLOT_W'(count)};
    end else if (cmd.repoint_wr) begin
      slot_wa = hm;
      slot_wd = {1'b1, last_val, pos};
    end else if (cmd.clear_wr) begin
      slot_wa = s;
    end
  end

  always_comb begin
    dense_we = cmd.ins_wr || cmd.move_wr;
    dense_wa = cmd.ins_wr ? SLOT_W'(count) : pos;
    dense_wd = cmd.ins_wr ? val : dense_q;
    dense_re = cmd.last_rd || cmd.pick_rd;
    dense_ra = cmd.pick_rd ? SLOT_W'(rem) : SLOT_W'(count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (cmd.slot_rd) slot_q <= slot_mem[hm];
  end

  always_ff @(posedge clk) begin
    if (dense_we) dense_mem[dense_wa] <= dense_wd;
    if (dense_re) dense_q <= dense_mem[dense_ra];
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.op;
      val <= req.value;
    end
    if (cmd.hash_init) begin
      h    <= BASIS_LO;
      hcnt <= '0;
      hsrc <= cmd.hash_src_last ? dense_q : val;
    end else if (cmd.hash_step) begin
      h    <= SLOT_W'(hx * PRIME_LO);
      hcnt <= hcnt + 2'd1;
      hsrc <= hsrc >> 8;
    end
    if (cmd.slot_keep) s <= hm;
    if (cmd.pos_keep) pos <= slot_q[SLOT_W-1:0];
    if (cmd.move_wr) last_val <= dense_q;
    if (cmd.load) dsh <= req.random_draw;
    if (cmd.div_init) begin
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dsh  <= dsh << 1;
      dcnt <= dcnt + DCW'(1);
      if (rs >= {1'b0, count}) rem <= CNT_W'(rs - {1'b0, count});
      else rem <= CNT_W'(rs);
    end
    if (cmd.finish) begin
      rsp.status       <= cmd.status;
      rsp.picked_value <= (op == hswrp_pkg::OP_PICK && cmd.status == hswrp_pkg::ST_OK)
                          ? dense_q : '0;
      rsp.count_after  <= hswrp_pkg::COUNT_W'(count);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + SLOT_W'(1);
      if (cmd.ins_wr) count <= count + CNT_W'(1);
      else if (cmd.clear_wr) count <= count - CNT_W'(1);
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op         = op;
    sts.hash_last  = (hcnt == 2'd3);
    sts.slot_used  = slot_q[SW-1];
    sts.key_match  = (slot_q[SLOT_W +: VW] == val);
    sts.count_zero = (count == '0);
    sts.count_full = (count == CNT_W'(SLOTS));
    sts.div_last   = (dcnt == DCW'(DW - 1));
    sts.clr_last   = (clr_idx == SLOT_W'(SLOTS - 1));
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

### rtl/hashed_set_with_random_pick.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hashed_set_with_random_pick
// Set of 32-bit values with insert, remove and random pick. A value lives in
// the slot given by the low bits of its FNV-1a hash and in a dense list.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   req     | in  | req_valid, req_stall | op, value, random_draw
//   rsp     | out | rsp_valid, rsp_stall | status, picked_value, count_after
//
// One item is processed at a time, from acceptance to result loaded. A pick
// on a non-empty set takes one remainder bit per cycle over the 31-bit draw;
// a remove of a member also moves the last list entry and repoints its slot.
// The hash takes one byte a cycle through one multiplier.
// After reset the slot table is swept clear with req_stall held high. A
// result waiting on rsp_stall does not block the next item's acceptance; it
// blocks only that item's completion.
// ---------------------------------------------------------------------------
module hashed_set_with_random_pick #(
  parameter int SLOTS = hswrp_pkg::SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  hswrp_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output hswrp_pkg::rsp_t rsp
);

  hswrp_pkg::cmd_t cmd;
  hswrp_pkg::sts_t sts;

  // accept only while the sequencer waits for work
  assign req_stall = !cmd.idle;

  // sequence: decode, hash, table reads and writes, remainder, deliver
  hswrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold tables, hash and remainder units and the result register
  hswrp_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### rtl/hswrp_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hswrp_chk
// Port-level checks for the hashed set, bound to the top level.
// ---------------------------------------------------------------------------
`include "hashed_set_with_random_pick_macros.svh"

module hswrp_chk #(
  parameter int SLOTS = hswrp_pkg::SLOTS_DEF
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input hswrp_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input hswrp_pkg::rsp_t rsp
);

  `HSWRP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
    "hswrp: accepted item did not make the block busy")
  `HSWRP_ASSERT_SAME(a_pick_zero_on_fail, rsp_valid && rsp.status != hswrp_pkg::ST_OK,
    rsp.picked_value == '0, "hswrp: picked value set on failure")
  `HSWRP_ASSERT_SAME(a_empty_count, rsp_valid && rsp.status == hswrp_pkg::ST_EMPTY,
    rsp.count_after == '0, "hswrp: empty status with members")
  `HSWRP_ASSERT_SAME(a_count_bound, rsp_valid, rsp.count_after <= SLOTS,
    "hswrp: count above table size")
  `HSWRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp),
    "hswrp: stalled result changed")

endmodule

bind hashed_set_with_random_pick hswrp_chk #(.SLOTS(SLOTS)) u_chk (.*);

### tb/hashed_set_with_random_pick_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hashed_set_with_random_pick_tb
// Drives insert, remove and random-pick items into the hashed set. It tracks
// a shadow copy of the slot table and the dense list, and it checks every
// result field by field, in order, against the predicted result.
// ---------------------------------------------------------------------------
module hashed_set_with_random_pick_tb;

  localparam int NSLOT = 1024;
  localparam int N_RANDOM = 950;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  hswrp_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  hswrp_pkg::rsp_t rsp;

  hashed_set_with_random_pick #(.SLOTS(NSLOT)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Shadow state of the set.
  logic        sh_used [NSLOT];
  logic [31:0] sh_key  [NSLOT];
  logic [9:0]  sh_pos  [NSLOT];
  logic [31:0] sh_list [NSLOT];
  int unsigned sh_count;

  hswrp_pkg::req_t pending_items[$];
  hswrp_pkg::rsp_t expected_rsps[$];
  int   n_errors;
  int   n_accepted;
  int   n_total;
  logic req_taken;  // item accepted at the last rising edge
  logic stim_done;
  logic hold_rsp;   // long receiver hold-off, set by its own process

  // Keep every value the stimulus has inserted, so removes and re-inserts hit.
  logic [31:0] member_pool[$];

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic logic [9:0] fnv_slot(logic [31:0] v);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    for (int b = 0; b < 4; b++) begin
      h = h ^ {56'd0, v[8*b +: 8]};
      h = h * 64'h00000100000001b3;
    end
    return h[9:0];
  endfunction

  // Apply one item to the shadow set and return its expected result.
  function automatic hswrp_pkg::rsp_t apply_set_op(hswrp_pkg::req_t it);
    hswrp_pkg::rsp_t r;
    logic [9:0] s, ls;
    logic [31:0] v, lastv;
    int unsigned pos;
    v = it.value;
    r = '0;
    r.status = hswrp_pkg::ST_OK;
    case (it.op)
      hswrp_pkg::OP_INSERT: begin
        s = fnv_slot(v);
        if (sh_used[s]) begin
          r.status = (sh_key[s] == v) ? hswrp_pkg::ST_PRESENT : hswrp_pkg::ST_COLLIDE;
        end else if (sh_count < NSLOT) begin
          sh_list[sh_count] = v;
          sh_pos[s] = sh_count[9:0];
          sh_key[s] = v;
          sh_used[s] = 1'b1;
          sh_count++;
        end
      end
      hswrp_pkg::OP_REMOVE: begin
        s = fnv_slot(v);
        if (!sh_used[s] || sh_key[s] != v || sh_count == 0) begin
          r.status = hswrp_pkg::ST_ABSENT;
        end else begin
          pos = sh_pos[s];
          lastv = sh_list[sh_count - 1];
          sh_list[pos] = lastv;
          ls = fnv_slot(lastv);
          sh_pos[ls] = pos[9:0];
          sh_count--;
          sh_used[s] = 1'b0;
          sh_key[s] = '0;
        end
      end
      hswrp_pkg::OP_PICK: begin
        if (sh_count == 0) r.status = hswrp_pkg::ST_EMPTY;
        else r.picked_value = sh_list[(it.random_draw % sh_count) % NSLOT];
      end
      default: ;
    endcase
    r.count_after = sh_count[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic hswrp_pkg::req_t mk_item(logic [1:0] op, logic [31:0] v,
                                              logic [30:0] d);
    hswrp_pkg::req_t it;
    it.op = op;
    it.value = v;
    it.random_draw = d;
    return it;
  endfunction

  // Driver: present items at the falling edge, advance when accepted.
  int unsigned drv_gap;
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      drv_gap = 0;
    end else if (req_taken) begin
      // item taken at the last rising edge
      if (drv_gap == 0) drv_gap = gap_len();
      if (drv_gap == 0 && pending_items.size() > 0) begin
        req <= pending_items.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (drv_gap > 0) drv_gap--;
      else if (pending_items.size() > 0) begin
        req <= pending_items.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // Predict at acceptance: the rising edge where valid is high and stall low.
  always @(posedge clk) begin
    req_taken = !rst && req_valid && !req_stall;
    if (req_taken) begin
      expected_rsps.push_back(apply_set_op(req));
      n_accepted++;
    end
  end

  // Receiver stall: random gaps, plus a long hold while hold_rsp is set.
  int unsigned stall_left;
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_rsp) begin
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      rsp_stall <= (stall_left > 0);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    hswrp_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.picked_value !== want.picked_value)
          report_mismatch("picked_value", rsp.picked_value, want.picked_value);
        if (rsp.count_after !== want.count_after)
          report_mismatch("count_after", 32'(rsp.count_after), 32'(want.count_after));
      end
    end
  end

  // Pick a value: a known member half the time, else a fresh random one.
  function automatic logic [31:0] pick_value();
    if (member_pool.size() > 0 && $urandom_range(0, 99) < 50)
      return member_pool[$urandom_range(0, member_pool.size() - 1)];
    return $urandom();
  endfunction

  task automatic push_item(hswrp_pkg::req_t it);
    pending_items.push_back(it);
    if (it.op == hswrp_pkg::OP_INSERT) member_pool.push_back(it.value);
  endtask

  // Long hold-off: the sender keeps going while the receiver waits.
  initial begin
    hold_rsp = 1'b0;
    wait (!rst);
    repeat (NSLOT + 400) @(posedge clk);
    @(negedge clk);
    hold_rsp = 1'b1;
    repeat (600) @(posedge clk);
    @(negedge clk);
    hold_rsp = 1'b0;
  end

  initial begin
    int unsigned k;
    logic [1:0] op;
    n_errors = 0;
    n_accepted = 0;
    stim_done = 1'b0;
    sh_count = 0;
    for (int i = 0; i < NSLOT; i++) sh_used[i] = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;

    // Directed: empty pick, extremes, duplicate, absent remove, remove of
    // last list entry, remove of an inner entry, and the unused op code.
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'h0, 31'h7fffffff));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'h1234, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_INSERT, 32'h80000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_INSERT, 32'h7fffffff, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_INSERT, 32'hffffffff, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_INSERT, 32'h00000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_INSERT, 32'h80000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'h0, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'hffffffff, 31'h7fffffff));
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'h0, 31'h55555555));
    push_item(mk_item(2'd3, 32'hdeadbeef, 31'h2aaaaaaa));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'h00000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'h80000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'h80000000, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'h0, 31'h1));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'h7fffffff, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_REMOVE, 32'hffffffff, 31'h0));
    push_item(mk_item(hswrp_pkg::OP_PICK, 32'h0, 31'h3));

    // Random: inserts outnumber removes early so the table fills and
    // collisions show up, then the mix evens out.
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 99);
      if (n < 500)
        op = (k < 55) ? hswrp_pkg::OP_INSERT : (k < 75) ? hswrp_pkg::OP_REMOVE :
             (k < 97) ? hswrp_pkg::OP_PICK : 2'd3;
      else
        op = (k < 35) ? hswrp_pkg::OP_INSERT : (k < 70) ? hswrp_pkg::OP_REMOVE :
             (k < 97) ? hswrp_pkg::OP_PICK : 2'd3;
      push_item(mk_item(op, (op == hswrp_pkg::OP_INSERT && $urandom_range(0, 3) != 0) ?
                        $urandom() : pick_value(), 31'($urandom())));
    end
    n_total = pending_items.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (n_accepted == n_total);
    wait (expected_rsps.size() == 0);
    repeat (60) @(posedge clk);
    if (n_errors == 0) $display("hashed_set_with_random_pick_tb: done, clean");
    else $display("hashed_set_with_random_pick_tb: done, errors");
    $finish;
  end

  // Hard limit: generous against the slowest run (picks plus stalls).
  initial begin
    #2000000;
    $display("hashed_set_with_random_pick_tb: done, errors");
    $finish;
  end

endmodule
